// File: design/gmp_pkg.sv
package gmp_pkg;

  localparam int VAL_W     = 16;
  localparam int COST_W    = 32;
  localparam int ROW_OUT_W = 4;
  localparam int COL_OUT_W = 5;
  localparam int ROW_CNT_W = 5;
  localparam int COL_CNT_W = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic KIND_COST = 1'b0;
  localparam logic KIND_PATH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic [1:0] PICK_FIRST  = 2'd0;
  localparam logic [1:0] PICK_SECOND = 2'd1;
  localparam logic [1:0] PICK_THIRD  = 2'd2;

  typedef struct packed {
    logic [1:0]               idx;
    logic signed [COST_W-1:0] val;
  } pick_t;

endpackage

// File: design/gmp_pick.sv
module gmp_pick (
  input  logic signed [gmp_pkg::COST_W-1:0] first_cost,
  input  logic signed [gmp_pkg::COST_W-1:0] second_cost,
  input  logic signed [gmp_pkg::COST_W-1:0] third_cost,
  output gmp_pkg::pick_t                    pick
);
  import gmp_pkg::*;

  always_comb begin
    pick.idx = PICK_FIRST;
    pick.val = first_cost;
    if (second_cost < pick.val) begin
      pick.idx = PICK_SECOND;
      pick.val = second_cost;
    end
    if (third_cost < pick.val) begin
      pick.idx = PICK_THIRD;
      pick.val = third_cost;
    end
  end

endmodule

// File: design/gmp_core.sv
module gmp_core #(
  parameter int RW = 4,
  parameter int CW = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [RW-1:0]                       row_last,
  input  logic [CW-1:0]                       col_last,
  input  logic                                load_clr,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gmp_pkg::VAL_W-1:0]    in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_result_kind,
  output logic [gmp_pkg::ROW_OUT_W-1:0]       out_path_row,
  output logic [gmp_pkg::COL_OUT_W-1:0]       out_path_column,
  output logic signed [gmp_pkg::COST_W-1:0]   out_result_value,
  output logic                                out_last_result
);
  import gmp_pkg::*;

  localparam int KW     = RW + 1;
  localparam int AW     = RW + CW;
  localparam int DEPTH  = 2**AW;
  localparam int PDEPTH = 2**CW;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_RELAX  = 4'd1;
  localparam logic [3:0] ST_RDRAIN = 4'd2;
  localparam logic [3:0] ST_FIND   = 4'd3;
  localparam logic [3:0] ST_FDRAIN = 4'd4;
  localparam logic [3:0] ST_COST   = 4'd5;
  localparam logic [3:0] ST_TRACE  = 4'd6;
  localparam logic [3:0] ST_TWAIT  = 4'd7;
  localparam logic [3:0] ST_EMIT0  = 4'd8;
  localparam logic [3:0] ST_EMIT1  = 4'd9;
  localparam logic [3:0] ST_EMIT2  = 4'd10;

  logic signed [VAL_W-1:0]  grid_mem [DEPTH];
  logic signed [COST_W-1:0] cost_mem [DEPTH];
  logic [RW-1:0]            path_mem [PDEPTH];

  logic                     g_we, g_re;
  logic [AW-1:0]            g_waddr, g_raddr;
  logic signed [VAL_W-1:0]  g_rdata_r;
  logic                     c_we, c_re;
  logic [AW-1:0]            c_waddr, c_raddr;
  logic signed [COST_W-1:0] c_wdata, c_rdata_r;
  logic                     p_we, p_re;
  logic [CW-1:0]            p_waddr, p_raddr;
  logic [RW-1:0]            p_wdata, p_rdata_r;

  logic [3:0]               state_r, state_nxt;
  logic [RW-1:0]            lr_r, lr_nxt;
  logic [CW-1:0]            lc_r, lc_nxt;
  logic [CW-1:0]            col_r, col_nxt;
  logic [KW-1:0]            k_r, k_nxt, km1;
  logic [RW-1:0]            pos_r, pos_nxt;
  logic                     p1_v_r, p1_v_nxt;
  logic                     p1_calc_r, p1_calc_nxt;
  logic [RW-1:0]            p1_row_r, p1_row_nxt;
  logic                     p2_v_r, p2_v_nxt;
  logic [RW-1:0]            p2_row_r;
  logic signed [COST_W-1:0] a_r, b_r, m_r, best_v_r;
  logic signed [VAL_W-1:0]  g_r;
  logic [RW-1:0]            best_r;
  logic                     best_ld;
  logic [RW-1:0]            rd_row, cand0, cand1, cand2, cand_k, new_pos;
  logic                     accept, slot_free, out_load;
  logic                     out_valid_r;
  logic                     out_kind_r, out_kind_nxt;
  logic [ROW_OUT_W-1:0]     out_row_r, out_row_nxt;
  logic [COL_OUT_W-1:0]     out_col_r, out_col_nxt;
  logic signed [COST_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  pick_t                    pk;

  gmp_pick u_pick (
    .first_cost  (a_r),
    .second_cost (b_r),
    .third_cost  (c_rdata_r),
    .pick        (pk)
  );

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= in_element_value;
    end
    if (g_re) begin
      g_rdata_r <= grid_mem[g_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cost_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rdata_r <= cost_mem[c_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      path_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rdata_r <= path_mem[p_raddr];
    end
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign km1       = k_r - KW'(1);

  always_comb begin
    if (pos_r == '0) begin
      cand0 = row_last;
      cand1 = '0;
      cand2 = RW'(1);
    end else if (pos_r == row_last) begin
      cand0 = '0;
      cand1 = pos_r;
      cand2 = pos_r - RW'(1);
    end else begin
      cand0 = pos_r - RW'(1);
      cand1 = pos_r;
      cand2 = pos_r + RW'(1);
    end
    case (k_r[1:0])
      2'd0:    cand_k = cand0;
      2'd1:    cand_k = cand1;
      default: cand_k = cand2;
    endcase
    case (pk.idx)
      PICK_FIRST:  new_pos = cand0;
      PICK_SECOND: new_pos = cand1;
      default:     new_pos = cand2;
    endcase
    if (k_r == '0) begin
      rd_row = row_last;
    end else if (km1 <= KW'(row_last)) begin
      rd_row = RW'(km1);
    end else begin
      rd_row = '0;
    end
  end

  assign best_ld = p1_v_r && ((state_r == ST_FIND) || (state_r == ST_FDRAIN)) &&
                   ((p1_row_r == '0) || (c_rdata_r < best_v_r));

  always_comb begin
    state_nxt     = state_r;
    lr_nxt        = lr_r;
    lc_nxt        = lc_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    p1_v_nxt      = 1'b0;
    p1_calc_nxt   = 1'b0;
    p1_row_nxt    = p1_row_r;
    p2_v_nxt      = p1_v_r && p1_calc_r;
    g_we          = 1'b0;
    g_waddr       = {lr_r, lc_r};
    g_re          = 1'b0;
    g_raddr       = '0;
    c_we          = p2_v_r;
    c_waddr       = {p2_row_r, col_r};
    c_wdata       = m_r + {{(COST_W-VAL_W){g_r[VAL_W-1]}}, g_r};
    c_re          = 1'b0;
    c_raddr       = '0;
    p_we          = 1'b0;
    p_waddr       = col_r - CW'(1);
    p_wdata       = new_pos;
    p_re          = 1'b0;
    p_raddr       = col_r;
    out_load      = 1'b0;
    out_kind_nxt  = KIND_PATH;
    out_row_nxt   = ROW_OUT_W'(p_rdata_r);
    out_col_nxt   = COL_OUT_W'(col_r);
    out_value_nxt = {{(COST_W-VAL_W){g_rdata_r[VAL_W-1]}}, g_rdata_r};
    out_last_nxt  = (col_r == col_last);

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          g_we = 1'b1;
          if (lc_r == '0) begin
            c_we    = 1'b1;
            c_waddr = {lr_r, lc_r};
            c_wdata = {{(COST_W-VAL_W){in_element_value[VAL_W-1]}}, in_element_value};
          end
          if (lc_r == col_last) begin
            lc_nxt = '0;
            if (lr_r == row_last) begin
              lr_nxt    = '0;
              col_nxt   = CW'(1);
              k_nxt     = '0;
              state_nxt = (col_last == '0) ? ST_FIND : ST_RELAX;
            end else begin
              lr_nxt = lr_r + RW'(1);
            end
          end else begin
            lc_nxt = lc_r + CW'(1);
          end
        end
      end
      ST_RELAX: begin
        c_re        = 1'b1;
        c_raddr     = {rd_row, col_r - CW'(1)};
        p1_v_nxt    = 1'b1;
        p1_calc_nxt = (k_r >= KW'(2));
        p1_row_nxt  = RW'(k_r - KW'(2));
        if (k_r >= KW'(2)) begin
          g_re    = 1'b1;
          g_raddr = {RW'(k_r - KW'(2)), col_r};
        end
        if (k_r == KW'(row_last) + KW'(2)) begin
          state_nxt = ST_RDRAIN;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_RDRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          k_nxt = '0;
          if (col_r == col_last) begin
            state_nxt = ST_FIND;
          end else begin
            col_nxt   = col_r + CW'(1);
            state_nxt = ST_RELAX;
          end
        end
      end
      ST_FIND: begin
        c_re       = 1'b1;
        c_raddr    = {RW'(k_r), col_last};
        p1_v_nxt   = 1'b1;
        p1_row_nxt = RW'(k_r);
        if (k_r == KW'(row_last)) begin
          state_nxt = ST_FDRAIN;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_FDRAIN: begin
        if (!p1_v_r) begin
          state_nxt = ST_COST;
        end
      end
      ST_COST: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_COST;
          out_row_nxt   = ROW_OUT_W'(best_r);
          out_col_nxt   = '0;
          out_value_nxt = best_v_r;
          out_last_nxt  = 1'b0;
          p_we          = 1'b1;
          p_waddr       = col_last;
          p_wdata       = best_r;
          pos_nxt       = best_r;
          col_nxt       = col_last;
          k_nxt         = '0;
          state_nxt     = (col_last == '0) ? ST_EMIT0 : ST_TRACE;
        end
      end
      ST_TRACE: begin
        c_re     = 1'b1;
        c_raddr  = {cand_k, col_r - CW'(1)};
        p1_v_nxt = 1'b1;
        if (k_r == KW'(2)) begin
          state_nxt = ST_TWAIT;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_TWAIT: begin
        p_we    = 1'b1;
        pos_nxt = new_pos;
        k_nxt   = '0;
        col_nxt = col_r - CW'(1);
        if (col_r == CW'(1)) begin
          state_nxt = ST_EMIT0;
        end else begin
          state_nxt = ST_TRACE;
        end
      end
      ST_EMIT0: begin
        p_re      = 1'b1;
        state_nxt = ST_EMIT1;
      end
      ST_EMIT1: begin
        g_re      = 1'b1;
        g_raddr   = {p_rdata_r, col_r};
        state_nxt = ST_EMIT2;
      end
      ST_EMIT2: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (col_r == col_last) begin
            state_nxt = ST_LOAD;
          end else begin
            col_nxt   = col_r + CW'(1);
            state_nxt = ST_EMIT0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (load_clr) begin
      lr_nxt = '0;
      lc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      lr_r        <= '0;
      lc_r        <= '0;
      p1_v_r      <= 1'b0;
      p1_calc_r   <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lr_r      <= lr_nxt;
      lc_r      <= lc_nxt;
      p1_v_r    <= p1_v_nxt;
      p1_calc_r <= p1_calc_nxt;
      p2_v_r    <= p2_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    k_r      <= k_nxt;
    pos_r    <= pos_nxt;
    p1_row_r <= p1_row_nxt;
    if (p1_v_r) begin
      a_r <= b_r;
      b_r <= c_rdata_r;
    end
    if (p1_v_r && p1_calc_r) begin
      m_r      <= pk.val;
      g_r      <= g_rdata_r;
      p2_row_r <= p1_row_r;
    end
    if (best_ld) begin
      best_v_r <= c_rdata_r;
      best_r   <= p1_row_r;
    end
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_value_r <= out_value_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_path_row     = out_row_r;
  assign out_path_column  = out_col_r;
  assign out_result_value = out_value_r;
  assign out_last_result  = out_last_r;

endmodule

// File: design/grid_min_path_wraparound.sv
// Channel   Handshake                Payload
// in        in_valid / in_ready      in_element_value
// out       out_valid / out_ready    out_result_kind, out_path_row, out_path_column,
//                                    out_result_value, out_last_result
// cfg       cfg_we                   cfg_index, cfg_data
//
// Load takes one cycle per cell. After the last cell the grid is closed out on the
// single read port of the cost memory: column-by-column relaxation, the last-column
// minimum, column-by-column traceback, then a path and a grid read per path element.
// Input is not taken from the last cell until the final path element is registered.
// Synchronous active-low reset clears control and sets 16 rows by 32 columns.
// A stalled output holds the sequencer at the next transfer.
module grid_min_path_wraparound #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [gmp_pkg::VAL_W-1:0]    in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_result_kind,
  output logic [gmp_pkg::ROW_OUT_W-1:0]       out_path_row,
  output logic [gmp_pkg::COL_OUT_W-1:0]       out_path_column,
  output logic signed [gmp_pkg::COST_W-1:0]   out_result_value,
  output logic                                out_last_result,
  input  logic                                cfg_we,
  input  logic [gmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gmp_pkg::CFG_W-1:0]           cfg_data
);
  import gmp_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [ROW_CNT_W-1:0] row_count_r;
  logic [COL_CNT_W-1:0] column_count_r;
  logic [RW-1:0]        row_last;
  logic [CW-1:0]        col_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_CNT_W'(16);
      column_count_r <= COL_CNT_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count_r    <= cfg_data[ROW_CNT_W-1:0];
        REG_COL_COUNT: column_count_r <= cfg_data[COL_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (int'(row_count_r) < 2) begin
      row_last = RW'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      row_last = RW'(MAX_ROWS - 1);
    end else begin
      row_last = RW'(row_count_r - ROW_CNT_W'(1));
    end
    if (column_count_r == '0) begin
      col_last = '0;
    end else if (int'(column_count_r) > MAX_COLS) begin
      col_last = CW'(MAX_COLS - 1);
    end else begin
      col_last = CW'(column_count_r - COL_CNT_W'(1));
    end
  end

  gmp_core #(
    .RW (RW),
    .CW (CW)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .row_last         (row_last),
    .col_last         (col_last),
    .load_clr         (cfg_we),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_path_row     (out_path_row),
    .out_path_column  (out_path_column),
    .out_result_value (out_result_value),
    .out_last_result  (out_last_result)
  );

  a_cost_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_COST)) |-> !in_ready)
    else $error("input ready while cost result pending");

  a_last_on_path_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |-> (out_result_kind == KIND_PATH))
    else $error("last flag on cost result");

  a_cost_column_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_COST)) |-> (out_path_column == '0))
    else $error("cost result with nonzero column");

endmodule
